FILE: rtl/core/srf_pkg.sv
package srf_pkg;

    // Node table size and derived widths
    localparam int NODE_COUNT = 8;
    localparam int NODE_IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam logic [NODE_IDX_W-1:0] NODE_LAST = NODE_IDX_W'(NODE_COUNT - 1);

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int IDX_W   = 3;
    localparam int TIME_W  = 32;
    localparam int TRIG_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 16;
    localparam int SUB_W   = 3;

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd300;

    // Bytes per online node in the frame
    localparam logic [LEN_W-1:0] NODE_BYTES = 16'd7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_REQUEST = 2'd1,
        FUNC_POLL    = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAD     = 2'd0,
        REG_DEST     = 2'd1,
        REG_CMD      = 2'd2,
        REG_INTERVAL = 2'd3
    } reg_idx_t;

    // Header byte positions
    localparam logic [SUB_W-1:0] HB_HEAD  = 3'd0;
    localparam logic [SUB_W-1:0] HB_DEST  = 3'd1;
    localparam logic [SUB_W-1:0] HB_CMD   = 3'd2;
    localparam logic [SUB_W-1:0] HB_SEQ   = 3'd3;
    localparam logic [SUB_W-1:0] HB_LENH  = 3'd4;
    localparam logic [SUB_W-1:0] HB_LENL  = 3'd5;

    // Node record byte positions
    localparam logic [SUB_W-1:0] NB_ID  = 3'd0;
    localparam logic [SUB_W-1:0] NB_TS0 = 3'd1;
    localparam logic [SUB_W-1:0] NB_TS1 = 3'd2;
    localparam logic [SUB_W-1:0] NB_TS2 = 3'd3;
    localparam logic [SUB_W-1:0] NB_TS3 = 3'd4;
    localparam logic [SUB_W-1:0] NB_CT0 = 3'd5;
    localparam logic [SUB_W-1:0] NB_CT1 = 3'd6;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_NODE = 2'd1,
        PH_SUM  = 2'd2
    } phase_t;

    typedef struct packed {
        logic                  ready;
        logic                  stamp;
        logic                  start_frame;
        logic                  emit;
        logic                  finish;
        phase_t                phase;
        logic [SUB_W-1:0]      sub;
        logic [NODE_IDX_W-1:0] ptr;
    } ctrl_cmd_t;

    typedef struct packed {
        logic accept;
        logic is_poll;
        logic pending;
        logic early;
        logic any_online;
        logic node_on;
        logic load;
    } dp_status_t;

    typedef struct packed {
        logic                en;
        reg_idx_t            idx;
        logic [APB_DW-1:0]   data;
    } cfg_wr_t;

endpackage

FILE: rtl/core/srf_if.sv
interface srf_item_if;
    logic                          valid;
    logic                          ready;
    logic [srf_pkg::FUNC_W-1:0]    func;
    logic [srf_pkg::TIME_W-1:0]    now_ms;
    logic [srf_pkg::IDX_W-1:0]     node_index;
    logic                          node_online;
    logic [srf_pkg::TIME_W-1:0]    node_timestamp;
    logic [srf_pkg::TRIG_W-1:0]    node_trigger_count;

    modport source (
        output valid, func, now_ms, node_index, node_online, node_timestamp,
               node_trigger_count,
        input  ready
    );
    modport sink (
        input  valid, func, now_ms, node_index, node_online, node_timestamp,
               node_trigger_count,
        output ready
    );
endinterface

interface srf_frame_if;
    logic                          valid;
    logic                          ready;
    logic [srf_pkg::BYTE_W-1:0]    frame_byte;
    logic                          frame_last;

    modport source (
        output valid, frame_byte, frame_last,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, frame_last,
        output ready
    );
endinterface

FILE: rtl/core/srf_ctrl.sv
module srf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  srf_pkg::dp_status_t status,
    output srf_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_HEAD  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_NODE  = 6'b010000,
        S_SUM   = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic [srf_pkg::SUB_W-1:0]         sub_reg, sub_next;
    logic [srf_pkg::NODE_IDX_W-1:0]    ptr_reg, ptr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sub_reg   <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sub_reg   <= sub_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sub_next        = sub_reg;
        ptr_next        = ptr_reg;
        cmd.ready       = 1'b0;
        cmd.stamp       = 1'b0;
        cmd.start_frame = 1'b0;
        cmd.emit        = 1'b0;
        cmd.finish      = 1'b0;
        cmd.phase       = srf_pkg::PH_HEAD;
        cmd.sub         = sub_reg;
        cmd.ptr         = ptr_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (status.accept)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                if (status.is_poll && status.pending && !status.early)
                begin
                    cmd.stamp = 1'b1;
                    if (status.any_online)
                    begin
                        cmd.start_frame = 1'b1;
                        sub_next        = '0;
                        ptr_next        = '0;
                        state_next      = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                cmd.emit  = 1'b1;
                cmd.phase = srf_pkg::PH_HEAD;
                if (status.load)
                begin
                    if (sub_reg == srf_pkg::HB_LENL)
                    begin
                        sub_next   = '0;
                        state_next = S_SCAN;
                    end
                    else
                        sub_next = sub_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                // skip offline nodes one per cycle
                if (status.node_on)
                begin
                    sub_next   = '0;
                    state_next = S_NODE;
                end
                else if (ptr_reg == srf_pkg::NODE_LAST)
                    state_next = S_SUM;
                else
                    ptr_next = ptr_reg + 1'b1;
            end
            S_NODE:
            begin
                cmd.emit  = 1'b1;
                cmd.phase = srf_pkg::PH_NODE;
                if (status.load)
                begin
                    if (sub_reg == srf_pkg::NB_CT1)
                    begin
                        sub_next = '0;
                        if (ptr_reg == srf_pkg::NODE_LAST)
                            state_next = S_SUM;
                        else
                        begin
                            ptr_next   = ptr_reg + 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    else
                        sub_next = sub_reg + 1'b1;
                end
            end
            S_SUM:
            begin
                cmd.emit  = 1'b1;
                cmd.phase = srf_pkg::PH_SUM;
                if (status.load)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        status.accept |=> state_reg == S_CHECK)
        else $error("accepted item did not move to check");

    a_sum_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && status.load) |=> state_reg == S_IDLE)
        else $error("frame did not end after checksum byte");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !cmd.emit)
        else $error("byte emitted while taking items");

endmodule

FILE: rtl/core/srf_dp.sv
module srf_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    srf_item_if.sink                            item_in,
    srf_frame_if.source                         frame_out,
    input  srf_pkg::cfg_wr_t                    cfg_wr,
    input  logic [srf_pkg::CFG_IDX_W-1:0]       cfg_rd_idx,
    output logic [srf_pkg::APB_DW-1:0]          cfg_rd_data,
    input  srf_pkg::ctrl_cmd_t                  cmd,
    output srf_pkg::dp_status_t                 status
);

    logic [srf_pkg::BYTE_W-1:0]    head_reg, dest_reg, cmd_byte_reg;
    logic [srf_pkg::TIME_W-1:0]    interval_reg;

    logic [srf_pkg::NODE_COUNT-1:0] online_reg;
    logic [srf_pkg::TIME_W-1:0]    ts_mem [srf_pkg::NODE_COUNT];
    logic [srf_pkg::TRIG_W-1:0]    ct_mem [srf_pkg::NODE_COUNT];

    logic                          pending_reg;
    logic [srf_pkg::BYTE_W-1:0]    seq_reg;
    logic [srf_pkg::TIME_W-1:0]    last_send_reg;

    srf_pkg::func_t                func_reg;
    logic [srf_pkg::TIME_W-1:0]    now_reg;
    logic [srf_pkg::BYTE_W-1:0]    sum_reg;

    logic                          out_valid_reg;
    logic [srf_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                          out_last_reg;

    logic                          accept;
    logic                          load;
    logic                          idx_ok;
    logic [srf_pkg::CNT_W-1:0]     online_cnt;
    logic [srf_pkg::LEN_W-1:0]     payload_len;
    logic [srf_pkg::TIME_W-1:0]    elapsed;
    logic [srf_pkg::TIME_W-1:0]    node_ts;
    logic [srf_pkg::TRIG_W-1:0]    node_ct;
    logic [srf_pkg::BYTE_W-1:0]    byte_sel;
    logic                          byte_summed;

    assign item_in.ready = cmd.ready;
    assign accept        = item_in.valid && cmd.ready;
    assign load          = cmd.emit && (!out_valid_reg || frame_out.ready);
    assign idx_ok        = 32'(item_in.node_index) < srf_pkg::NODE_COUNT;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            dest_reg     <= '0;
            cmd_byte_reg <= '0;
            interval_reg <= srf_pkg::INTERVAL_RESET;
        end
        else if (cfg_wr.en)
        begin
            case (cfg_wr.idx)
                srf_pkg::REG_HEAD:     head_reg     <= cfg_wr.data[srf_pkg::BYTE_W-1:0];
                srf_pkg::REG_DEST:     dest_reg     <= cfg_wr.data[srf_pkg::BYTE_W-1:0];
                srf_pkg::REG_CMD:      cmd_byte_reg <= cfg_wr.data[srf_pkg::BYTE_W-1:0];
                srf_pkg::REG_INTERVAL: interval_reg <= cfg_wr.data[srf_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_rd_idx)
            srf_pkg::REG_HEAD:     cfg_rd_data = srf_pkg::APB_DW'(head_reg);
            srf_pkg::REG_DEST:     cfg_rd_data = srf_pkg::APB_DW'(dest_reg);
            srf_pkg::REG_CMD:      cfg_rd_data = srf_pkg::APB_DW'(cmd_byte_reg);
            srf_pkg::REG_INTERVAL: cfg_rd_data = srf_pkg::APB_DW'(interval_reg);
            default:               cfg_rd_data = '0;
        endcase
    end

    // node table payload: no reset, entries are valid once written
    always_ff @(posedge clk)
    begin
        if (accept && item_in.func == srf_pkg::FUNC_WRITE && idx_ok)
        begin
            ts_mem[item_in.node_index[srf_pkg::NODE_IDX_W-1:0]] <= item_in.node_timestamp;
            ct_mem[item_in.node_index[srf_pkg::NODE_IDX_W-1:0]] <= item_in.node_trigger_count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= srf_pkg::func_t'(item_in.func);
            now_reg  <= item_in.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg    <= '0;
            pending_reg   <= 1'b0;
            seq_reg       <= '0;
            last_send_reg <= '0;
        end
        else
        begin
            if (accept && item_in.func == srf_pkg::FUNC_WRITE && idx_ok)
                online_reg[item_in.node_index[srf_pkg::NODE_IDX_W-1:0]] <= item_in.node_online;
            if (accept && item_in.func == srf_pkg::FUNC_REQUEST)
                pending_reg <= 1'b1;
            else if (cmd.stamp)
                pending_reg <= 1'b0;
            if (cmd.stamp)
                last_send_reg <= now_reg;
            if (cmd.finish)
                seq_reg <= seq_reg + 1'b1;
        end
    end

    always_comb
    begin
        online_cnt = '0;
        for (int i = 0; i < srf_pkg::NODE_COUNT; i++)
            online_cnt = online_cnt + srf_pkg::CNT_W'(online_reg[i]);
    end

    assign payload_len = srf_pkg::LEN_W'(online_cnt) * srf_pkg::NODE_BYTES;
    assign elapsed     = now_reg - last_send_reg;
    assign node_ts     = ts_mem[cmd.ptr];
    assign node_ct     = ct_mem[cmd.ptr];

    always_comb
    begin
        byte_sel    = sum_reg;
        byte_summed = 1'b1;
        case (cmd.phase)
            srf_pkg::PH_HEAD:
            begin
                case (cmd.sub)
                    srf_pkg::HB_HEAD:
                    begin
                        byte_sel    = head_reg;
                        byte_summed = 1'b0;
                    end
                    srf_pkg::HB_DEST: byte_sel = dest_reg;
                    srf_pkg::HB_CMD:  byte_sel = cmd_byte_reg;
                    srf_pkg::HB_SEQ:  byte_sel = seq_reg;
                    srf_pkg::HB_LENH: byte_sel = payload_len[15:8];
                    srf_pkg::HB_LENL: byte_sel = payload_len[7:0];
                    default:          byte_sel = '0;
                endcase
            end
            srf_pkg::PH_NODE:
            begin
                case (cmd.sub)
                    srf_pkg::NB_ID:  byte_sel = srf_pkg::BYTE_W'(cmd.ptr) + 1'b1;
                    srf_pkg::NB_TS0: byte_sel = node_ts[7:0];
                    srf_pkg::NB_TS1: byte_sel = node_ts[15:8];
                    srf_pkg::NB_TS2: byte_sel = node_ts[23:16];
                    srf_pkg::NB_TS3: byte_sel = node_ts[31:24];
                    srf_pkg::NB_CT0: byte_sel = node_ct[7:0];
                    srf_pkg::NB_CT1: byte_sel = node_ct[15:8];
                    default:         byte_sel = '0;
                endcase
            end
            default:
            begin
                byte_sel    = sum_reg;
                byte_summed = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_frame)
            sum_reg <= '0;
        else if (load && byte_summed)
            sum_reg <= sum_reg ^ byte_sel;
    end

    // output register: refill in the same cycle the sink drains it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (frame_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= (cmd.phase == srf_pkg::PH_SUM);
        end
    end

    assign frame_out.valid      = out_valid_reg;
    assign frame_out.frame_byte = out_byte_reg;
    assign frame_out.frame_last = out_last_reg;

    assign status.accept     = accept;
    assign status.is_poll    = (func_reg == srf_pkg::FUNC_POLL);
    assign status.pending    = pending_reg;
    assign status.early      = (elapsed < interval_reg);
    assign status.any_online = |online_reg;
    assign status.node_on    = online_reg[cmd.ptr];
    assign status.load       = load;

    a_last_tracks_sum: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_last_reg == $past(cmd.phase == srf_pkg::PH_SUM))
        else $error("last flag does not match checksum byte");

    a_stamp_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.stamp |=> !pending_reg && last_send_reg == $past(now_reg))
        else $error("stamp did not clear request or record time");

    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> seq_reg == $past(seq_reg) + 8'd1)
        else $error("sequence did not advance after frame");

endmodule

FILE: rtl/core/sensor_report_framer.sv
// Channel     Dir  Handshake          Payload
// item_in     in   valid/ready        func, now_ms, node_index, node_online,
//                                     node_timestamp, node_trigger_count
// frame_out   out  valid/ready        frame_byte, frame_last
// apb         in   psel/penable/pwrite paddr[3:2] register, pwdata / prdata
//
// Every item is accepted, then passes a check step that decides on a poll.
// A poll that sends emits six header bytes, scans every table entry whether
// online or not, emits seven bytes per online node and one checksum byte,
// and takes no new item until the checksum byte is loaded; one byte per cycle
// goes through the output register while the sink is not stalling.
// Reset clears the online bits, request, sequence, last send time and
// registers; node payload needs no clearing pass. A stalled sink holds the
// byte in the output register and holds the frame sequencer at its next byte.
module sensor_report_framer (
    input  logic                           clk,
    input  logic                           rst_n,
    srf_item_if.sink                       item_in,
    srf_frame_if.source                    frame_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srf_pkg::APB_AW-1:0]     paddr,
    input  logic [srf_pkg::APB_DW-1:0]     pwdata,
    output logic [srf_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    srf_pkg::ctrl_cmd_t   cmd;
    srf_pkg::dp_status_t  status;
    srf_pkg::cfg_wr_t     cfg_wr;
    logic [srf_pkg::CFG_IDX_W-1:0] cfg_idx;

    // word-aligned decode: register i at byte address 4*i
    assign cfg_idx     = paddr[srf_pkg::APB_AW-1:2];
    assign pready      = 1'b1;
    assign cfg_wr.en   = psel && penable && pwrite && pready;
    assign cfg_wr.idx  = srf_pkg::reg_idx_t'(cfg_idx);
    assign cfg_wr.data = pwdata;

    srf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    srf_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_in     (item_in),
        .frame_out   (frame_out),
        .cfg_wr      (cfg_wr),
        .cfg_rd_idx  (cfg_idx),
        .cfg_rd_data (prdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

FILE: dv/srf_frame_checker.sv
`timescale 1ns / 100ps

module srf_frame_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    srf_item_if                          item_mon,
    srf_frame_if                         frame_mon,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srf_pkg::APB_AW-1:0]   paddr,
    input  logic [srf_pkg::APB_DW-1:0]   pwdata,
    input  logic                         pready,
    output int unsigned                  mismatches,
    output int unsigned                  bytes_due
);

    typedef struct packed {
        logic [srf_pkg::BYTE_W-1:0] data;
        logic                       last;
    } frame_beat_t;

    // Register copies, written as the APB port writes them
    logic [srf_pkg::BYTE_W-1:0]  head_byte;
    logic [srf_pkg::BYTE_W-1:0]  dest_byte;
    logic [srf_pkg::BYTE_W-1:0]  cmd_byte;
    logic [srf_pkg::TIME_W-1:0]  min_gap_ms;

    // Node table and send state
    logic [srf_pkg::NODE_COUNT-1:0] node_on;
    logic [srf_pkg::TIME_W-1:0]     node_ts [srf_pkg::NODE_COUNT];
    logic [srf_pkg::TRIG_W-1:0]     node_ct [srf_pkg::NODE_COUNT];
    logic                           request_open;
    logic [srf_pkg::BYTE_W-1:0]     frame_seq;
    logic [srf_pkg::TIME_W-1:0]     last_sent_ms;

    frame_beat_t                frame_due [$];
    logic [srf_pkg::BYTE_W-1:0] frame_xor;
    frame_beat_t                want;
    int unsigned                fail_count;

    task automatic queue_byte(input logic [srf_pkg::BYTE_W-1:0] b);
        frame_due.push_back('{data: b, last: 1'b0});
        frame_xor ^= b;
    endtask

    task automatic predict_frame(input srf_pkg::func_t f,
                                 input logic [srf_pkg::TIME_W-1:0] now,
                                 input logic [srf_pkg::IDX_W-1:0] idx,
                                 input logic online,
                                 input logic [srf_pkg::TIME_W-1:0] ts,
                                 input logic [srf_pkg::TRIG_W-1:0] ct);
        int unsigned                live;
        logic [srf_pkg::LEN_W-1:0]  len;
        logic [srf_pkg::TIME_W-1:0] gap;
        live = 0;
        gap  = now - last_sent_ms;
        case (f)
            srf_pkg::FUNC_WRITE:
                if (int'(idx) < srf_pkg::NODE_COUNT)
                begin
                    node_on[idx] = online;
                    node_ts[idx] = ts;
                    node_ct[idx] = ct;
                end
            srf_pkg::FUNC_REQUEST:
                request_open = 1'b1;
            srf_pkg::FUNC_POLL:
                if (request_open && gap >= min_gap_ms)
                begin
                    for (int i = 0; i < srf_pkg::NODE_COUNT; i++)
                        if (node_on[i])
                            live++;
                    request_open = 1'b0;
                    last_sent_ms = now;
                    if (live != 0)
                    begin
                        len = srf_pkg::NODE_BYTES * srf_pkg::LEN_W'(live);
                        frame_due.push_back('{data: head_byte, last: 1'b0});
                        frame_xor = '0;
                        queue_byte(dest_byte);
                        queue_byte(cmd_byte);
                        queue_byte(frame_seq);
                        frame_seq = frame_seq + 8'd1;
                        queue_byte(len[15:8]);
                        queue_byte(len[7:0]);
                        for (int i = 0; i < srf_pkg::NODE_COUNT; i++)
                            if (node_on[i])
                            begin
                                queue_byte(srf_pkg::BYTE_W'(i + 1));
                                queue_byte(node_ts[i][7:0]);
                                queue_byte(node_ts[i][15:8]);
                                queue_byte(node_ts[i][23:16]);
                                queue_byte(node_ts[i][31:24]);
                                queue_byte(node_ct[i][7:0]);
                                queue_byte(node_ct[i][15:8]);
                            end
                        frame_due.push_back('{data: frame_xor, last: 1'b1});
                    end
                end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_byte    = '0;
            dest_byte    = '0;
            cmd_byte     = '0;
            min_gap_ms   = srf_pkg::INTERVAL_RESET;
            node_on      = '0;
            request_open = 1'b0;
            frame_seq    = '0;
            last_sent_ms = '0;
            frame_xor    = '0;
            fail_count   = 0;
            frame_due.delete();
            mismatches <= 0;
            bytes_due  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (srf_pkg::reg_idx_t'(paddr[3:2]))
                    srf_pkg::REG_HEAD:     head_byte  = pwdata[7:0];
                    srf_pkg::REG_DEST:     dest_byte  = pwdata[7:0];
                    srf_pkg::REG_CMD:      cmd_byte   = pwdata[7:0];
                    srf_pkg::REG_INTERVAL: min_gap_ms = pwdata[31:0];
                    default: ;
                endcase
            end

            if (frame_mon.valid && frame_mon.ready)
            begin
                if (frame_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%t: unexpected frame byte %02h last %0b", $time,
                                 frame_mon.frame_byte, frame_mon.frame_last);
                    fail_count++;
                end
                else
                begin
                    want = frame_due.pop_front();
                    if (frame_mon.frame_byte !== want.data ||
                        frame_mon.frame_last !== want.last)
                    begin
                        if (fail_count < 10)
                            $display("%t: frame byte expected %02h last %0b, got %02h last %0b",
                                     $time, want.data, want.last,
                                     frame_mon.frame_byte, frame_mon.frame_last);
                        fail_count++;
                    end
                end
            end

            if (item_mon.valid && item_mon.ready)
                predict_frame(srf_pkg::func_t'(item_mon.func), item_mon.now_ms,
                              item_mon.node_index, item_mon.node_online,
                              item_mon.node_timestamp, item_mon.node_trigger_count);

            mismatches <= fail_count;
            bytes_due  <= frame_due.size();
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;

    // Cycles allowed with no handshake of any kind before the run is abandoned
    localparam int STALL_LIMIT   = 2000;
    // Frame length bound plus decision cycles; covers a poll still in flight
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 75;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [srf_pkg::APB_AW-1:0]   paddr;
    logic [srf_pkg::APB_DW-1:0]   pwdata;
    logic [srf_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    // High during the stretch in which neither side idles
    logic                         steady;
    logic [srf_pkg::TIME_W-1:0]   clock_ms;
    int unsigned                  mismatches;
    int unsigned                  bytes_due;
    int unsigned                  quiet_cycles;

    srf_item_if  item_ch ();
    srf_frame_if frame_ch ();

    sensor_report_framer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_ch),
        .frame_out (frame_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    srf_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_mon   (item_ch),
        .frame_mon  (frame_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .bytes_due  (bytes_due)
    );

    always #1 clk = ~clk;

    // Frame sink: drop ready about a third of the time, never while steady
    always @(posedge clk)
        frame_ch.ready <= steady || ($urandom_range(0, 99) >= 33);

    // Watchdog: restart on any handshake, give up after a long silence
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((item_ch.valid && item_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
                 (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one item, idling beforehand at random, and hold it until taken.
    // Valid is left high on return so back-to-back items need no gap.
    task automatic send_item(input srf_pkg::func_t f,
                             input logic [srf_pkg::TIME_W-1:0] now,
                             input logic [srf_pkg::IDX_W-1:0] idx,
                             input logic online,
                             input logic [srf_pkg::TIME_W-1:0] ts,
                             input logic [srf_pkg::TRIG_W-1:0] ct);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid              <= 1'b1;
        item_ch.func               <= f;
        item_ch.now_ms             <= now;
        item_ch.node_index         <= idx;
        item_ch.node_online        <= online;
        item_ch.node_timestamp     <= ts;
        item_ch.node_trigger_count <= ct;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Shorthand for items whose payload the block ignores
    task automatic send_bare(input srf_pkg::func_t f,
                             input logic [srf_pkg::TIME_W-1:0] now);
        send_item(f, now, srf_pkg::IDX_W'($urandom()), 1'($urandom()), $urandom(),
                  srf_pkg::TRIG_W'($urandom()));
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input srf_pkg::reg_idx_t idx,
                             input logic [srf_pkg::APB_DW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid, wait for every predicted byte, then let a silent poll finish
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (bytes_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int                         pick;
        logic [srf_pkg::TIME_W-1:0] ts;
        logic [srf_pkg::TRIG_W-1:0] ct;
        logic [srf_pkg::TIME_W-1:0] when;

        // Hold every input at a known value from time zero
        clk                         = 1'b0;
        rst_n                       = 1'b0;
        steady                      = 1'b0;
        psel                        = 1'b0;
        penable                     = 1'b0;
        pwrite                      = 1'b0;
        paddr                       = '0;
        pwdata                      = '0;
        item_ch.valid               = 1'b0;
        item_ch.func                = srf_pkg::FUNC_WRITE;
        item_ch.now_ms              = '0;
        item_ch.node_index          = '0;
        item_ch.node_online         = 1'b0;
        item_ch.node_timestamp      = '0;
        item_ch.node_trigger_count  = '0;
        frame_ch.ready              = 1'b0;
        clock_ms                    = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run on the reset register values (interval 300).
        // Poll with nothing pending, then the unused function code.
        send_bare(srf_pkg::FUNC_POLL, 32'd1000);
        send_bare(srf_pkg::FUNC_NONE, $urandom());
        // Request, poll too early, then poll with no node online:
        // the request clears silently and the send time is stamped.
        send_bare(srf_pkg::FUNC_REQUEST, $urandom());
        send_bare(srf_pkg::FUNC_POLL, 32'd100);
        send_bare(srf_pkg::FUNC_POLL, 32'd500);
        send_bare(srf_pkg::FUNC_POLL, 32'd2000);
        // Fill the whole table, extremes in the first and last entries
        for (int k = 0; k < srf_pkg::NODE_COUNT; k++)
        begin
            ts = (k == 0) ? 32'h0 :
                 (k == srf_pkg::NODE_COUNT - 1) ? 32'hFFFF_FFFF : $urandom();
            ct = (k == 0) ? 16'h0 :
                 (k == srf_pkg::NODE_COUNT - 1) ? 16'hFFFF : srf_pkg::TRIG_W'($urandom());
            send_item(srf_pkg::FUNC_WRITE, $urandom(), srf_pkg::IDX_W'(k), 1'b1, ts, ct);
        end
        // Full-length frame
        send_bare(srf_pkg::FUNC_REQUEST, $urandom());
        send_bare(srf_pkg::FUNC_POLL, 32'd800);
        // Take one node offline; one ms short of the interval, then exactly on it
        send_item(srf_pkg::FUNC_WRITE, $urandom(), 3'd3, 1'b0, $urandom(),
                  srf_pkg::TRIG_W'($urandom()));
        send_bare(srf_pkg::FUNC_REQUEST, $urandom());
        send_bare(srf_pkg::FUNC_POLL, 32'd1099);
        send_bare(srf_pkg::FUNC_POLL, 32'd1100);
        // Send just before the counter wraps, then check the interval across the wrap
        send_bare(srf_pkg::FUNC_REQUEST, $urandom());
        send_bare(srf_pkg::FUNC_POLL, 32'hFFFF_FFF0);
        send_bare(srf_pkg::FUNC_REQUEST, $urandom());
        send_bare(srf_pkg::FUNC_POLL, 32'h0000_0100);
        send_bare(srf_pkg::FUNC_POLL, 32'h0000_011C);
        clock_ms = 32'h0000_011C;

        // Random phases, each under its own register settings
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    write_reg(srf_pkg::REG_HEAD, 32'h00);
                    write_reg(srf_pkg::REG_DEST, 32'hFF);
                    write_reg(srf_pkg::REG_CMD, 32'h00);
                    write_reg(srf_pkg::REG_INTERVAL, 32'd0);
                end
                1:
                begin
                    write_reg(srf_pkg::REG_HEAD, 32'($urandom_range(0, 255)));
                    write_reg(srf_pkg::REG_DEST, 32'($urandom_range(0, 255)));
                    write_reg(srf_pkg::REG_CMD, 32'hFF);
                    write_reg(srf_pkg::REG_INTERVAL, 32'($urandom_range(1, 1000)));
                end
                2:
                begin
                    write_reg(srf_pkg::REG_HEAD, 32'hFF);
                    write_reg(srf_pkg::REG_DEST, 32'($urandom_range(0, 255)));
                    write_reg(srf_pkg::REG_CMD, 32'($urandom_range(0, 255)));
                    write_reg(srf_pkg::REG_INTERVAL, 32'hFFFF_FFFF);
                end
                default:
                begin
                    write_reg(srf_pkg::REG_HEAD, 32'($urandom_range(0, 255)));
                    write_reg(srf_pkg::REG_DEST, 32'($urandom_range(0, 255)));
                    write_reg(srf_pkg::REG_CMD, 32'($urandom_range(0, 255)));
                    write_reg(srf_pkg::REG_INTERVAL, 32'd300);
                end
            endcase
            // No idling on either side for the whole of the second phase
            steady <= (phase == 1);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0:       ts = 32'h0;
                    1:       ts = 32'hFFFF_FFFF;
                    default: ts = $urandom();
                endcase
                case ($urandom_range(0, 9))
                    0:       ct = 16'h0;
                    1:       ct = 16'hFFFF;
                    default: ct = srf_pkg::TRIG_W'($urandom());
                endcase
                if (pick < 35)
                    send_item(srf_pkg::FUNC_WRITE, $urandom(),
                              srf_pkg::IDX_W'($urandom_range(0, srf_pkg::NODE_COUNT - 1)),
                              $urandom_range(0, 9) < 7, ts, ct);
                else if (pick < 55)
                    send_bare(srf_pkg::FUNC_REQUEST, $urandom());
                else if (pick < 90)
                begin
                    // Mostly advance time a little; sometimes jump anywhere, or step
                    // one ms back so the full-range interval can just be met
                    case ($urandom_range(0, 9))
                        0:       when = $urandom();
                        1:       when = clock_ms - 32'd1;
                        default: when = clock_ms + 32'($urandom_range(0, 400));
                    endcase
                    send_bare(srf_pkg::FUNC_POLL, when);
                    clock_ms = when;
                end
                else
                    send_bare(srf_pkg::FUNC_NONE, $urandom());
            end
        end

        drain();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/srf_pkg.sv
rtl/core/srf_if.sv
rtl/core/srf_ctrl.sv
rtl/core/srf_dp.sv
rtl/core/sensor_report_framer.sv
dv/srf_frame_checker.sv
dv/tb.sv
